// ===== sv/sn2d_pkg.sv =====
// Shared constants, types, the permutation ROM and functions for the 2D simplex noise unit.
`default_nettype none
package sn2d_pkg;
	localparam int FracBitsDefault = 16;
	localparam int PermEntries     = 256;
	localparam int Cfrac           = 24;
	localparam logic [23:0] F2Q24  = 24'd6140887;
	localparam logic [23:0] G2Q24  = 24'd3545443;
	localparam logic signed [27:0] OneQ24  = 28'sd16777216;
	localparam logic signed [27:0] HalfQ24 = 28'sd8388608;

	// per-corner word between the hash stage and the corner pipelines
	typedef struct packed {
		logic signed [27:0] dx;
		logic signed [27:0] dy;
		logic [3:0]         grad;
	} corner_t;

	function automatic logic [7:0] perm_at(input logic [7:0] k);
		logic [7:0] r;
		case (k)
			8'd0: r=8'd151; 8'd1: r=8'd160; 8'd2: r=8'd137; 8'd3: r=8'd91;
			8'd4: r=8'd90; 8'd5: r=8'd15; 8'd6: r=8'd131; 8'd7: r=8'd13;
			8'd8: r=8'd201; 8'd9: r=8'd95; 8'd10: r=8'd96; 8'd11: r=8'd53;
			8'd12: r=8'd194; 8'd13: r=8'd233; 8'd14: r=8'd7; 8'd15: r=8'd225;
			8'd16: r=8'd140; 8'd17: r=8'd36; 8'd18: r=8'd103; 8'd19: r=8'd30;
			8'd20: r=8'd69; 8'd21: r=8'd142; 8'd22: r=8'd8; 8'd23: r=8'd99;
			8'd24: r=8'd37; 8'd25: r=8'd240; 8'd26: r=8'd21; 8'd27: r=8'd10;
			8'd28: r=8'd23; 8'd29: r=8'd190; 8'd30: r=8'd6; 8'd31: r=8'd148;
			8'd32: r=8'd247; 8'd33: r=8'd120; 8'd34: r=8'd234; 8'd35: r=8'd75;
			8'd36: r=8'd0; 8'd37: r=8'd26; 8'd38: r=8'd197; 8'd39: r=8'd62;
			8'd40: r=8'd94; 8'd41: r=8'd252; 8'd42: r=8'd219; 8'd43: r=8'd203;
			8'd44: r=8'd117; 8'd45: r=8'd35; 8'd46: r=8'd11; 8'd47: r=8'd32;
			8'd48: r=8'd57; 8'd49: r=8'd177; 8'd50: r=8'd33; 8'd51: r=8'd88;
			8'd52: r=8'd237; 8'd53: r=8'd149; 8'd54: r=8'd56; 8'd55: r=8'd87;
			8'd56: r=8'd174; 8'd57: r=8'd20; 8'd58: r=8'd125; 8'd59: r=8'd136;
			8'd60: r=8'd171; 8'd61: r=8'd168; 8'd62: r=8'd68; 8'd63: r=8'd175;
			8'd64: r=8'd74; 8'd65: r=8'd165; 8'd66: r=8'd71; 8'd67: r=8'd134;
			8'd68: r=8'd139; 8'd69: r=8'd48; 8'd70: r=8'd27; 8'd71: r=8'd166;
			8'd72: r=8'd77; 8'd73: r=8'd146; 8'd74: r=8'd158; 8'd75: r=8'd231;
			8'd76: r=8'd83; 8'd77: r=8'd111; 8'd78: r=8'd229; 8'd79: r=8'd122;
			8'd80: r=8'd60; 8'd81: r=8'd211; 8'd82: r=8'd133; 8'd83: r=8'd230;
			8'd84: r=8'd220; 8'd85: r=8'd105; 8'd86: r=8'd92; 8'd87: r=8'd41;
			8'd88: r=8'd55; 8'd89: r=8'd46; 8'd90: r=8'd245; 8'd91: r=8'd40;
			8'd92: r=8'd244; 8'd93: r=8'd102; 8'd94: r=8'd143; 8'd95: r=8'd54;
			8'd96: r=8'd65; 8'd97: r=8'd25; 8'd98: r=8'd63; 8'd99: r=8'd161;
			8'd100: r=8'd1; 8'd101: r=8'd216; 8'd102: r=8'd80; 8'd103: r=8'd73;
			8'd104: r=8'd209; 8'd105: r=8'd76; 8'd106: r=8'd132; 8'd107: r=8'd187;
			8'd108: r=8'd208; 8'd109: r=8'd89; 8'd110: r=8'd18; 8'd111: r=8'd169;
			8'd112: r=8'd200; 8'd113: r=8'd196; 8'd114: r=8'd135; 8'd115: r=8'd130;
			8'd116: r=8'd116; 8'd117: r=8'd188; 8'd118: r=8'd159; 8'd119: r=8'd86;
			8'd120: r=8'd164; 8'd121: r=8'd100; 8'd122: r=8'd109; 8'd123: r=8'd198;
			8'd124: r=8'd173; 8'd125: r=8'd186; 8'd126: r=8'd3; 8'd127: r=8'd64;
			8'd128: r=8'd52; 8'd129: r=8'd217; 8'd130: r=8'd226; 8'd131: r=8'd250;
			8'd132: r=8'd124; 8'd133: r=8'd123; 8'd134: r=8'd5; 8'd135: r=8'd202;
			8'd136: r=8'd38; 8'd137: r=8'd147; 8'd138: r=8'd118; 8'd139: r=8'd126;
			8'd140: r=8'd255; 8'd141: r=8'd82; 8'd142: r=8'd85; 8'd143: r=8'd212;
			8'd144: r=8'd207; 8'd145: r=8'd206; 8'd146: r=8'd59; 8'd147: r=8'd227;
			8'd148: r=8'd47; 8'd149: r=8'd16; 8'd150: r=8'd58; 8'd151: r=8'd17;
			8'd152: r=8'd182; 8'd153: r=8'd189; 8'd154: r=8'd28; 8'd155: r=8'd42;
			8'd156: r=8'd223; 8'd157: r=8'd183; 8'd158: r=8'd170; 8'd159: r=8'd213;
			8'd160: r=8'd119; 8'd161: r=8'd248; 8'd162: r=8'd152; 8'd163: r=8'd2;
			8'd164: r=8'd44; 8'd165: r=8'd154; 8'd166: r=8'd163; 8'd167: r=8'd70;
			8'd168: r=8'd221; 8'd169: r=8'd153; 8'd170: r=8'd101; 8'd171: r=8'd155;
			8'd172: r=8'd167; 8'd173: r=8'd43; 8'd174: r=8'd172; 8'd175: r=8'd9;
			8'd176: r=8'd129; 8'd177: r=8'd22; 8'd178: r=8'd39; 8'd179: r=8'd253;
			8'd180: r=8'd19; 8'd181: r=8'd98; 8'd182: r=8'd108; 8'd183: r=8'd110;
			8'd184: r=8'd79; 8'd185: r=8'd113; 8'd186: r=8'd224; 8'd187: r=8'd232;
			8'd188: r=8'd178; 8'd189: r=8'd185; 8'd190: r=8'd112; 8'd191: r=8'd104;
			8'd192: r=8'd218; 8'd193: r=8'd246; 8'd194: r=8'd97; 8'd195: r=8'd228;
			8'd196: r=8'd251; 8'd197: r=8'd34; 8'd198: r=8'd242; 8'd199: r=8'd193;
			8'd200: r=8'd238; 8'd201: r=8'd210; 8'd202: r=8'd144; 8'd203: r=8'd12;
			8'd204: r=8'd191; 8'd205: r=8'd179; 8'd206: r=8'd162; 8'd207: r=8'd241;
			8'd208: r=8'd81; 8'd209: r=8'd51; 8'd210: r=8'd145; 8'd211: r=8'd235;
			8'd212: r=8'd249; 8'd213: r=8'd14; 8'd214: r=8'd239; 8'd215: r=8'd107;
			8'd216: r=8'd49; 8'd217: r=8'd192; 8'd218: r=8'd214; 8'd219: r=8'd31;
			8'd220: r=8'd181; 8'd221: r=8'd199; 8'd222: r=8'd106; 8'd223: r=8'd157;
			8'd224: r=8'd184; 8'd225: r=8'd84; 8'd226: r=8'd204; 8'd227: r=8'd176;
			8'd228: r=8'd115; 8'd229: r=8'd121; 8'd230: r=8'd50; 8'd231: r=8'd45;
			8'd232: r=8'd127; 8'd233: r=8'd4; 8'd234: r=8'd150; 8'd235: r=8'd254;
			8'd236: r=8'd138; 8'd237: r=8'd236; 8'd238: r=8'd205; 8'd239: r=8'd93;
			8'd240: r=8'd222; 8'd241: r=8'd114; 8'd242: r=8'd67; 8'd243: r=8'd29;
			8'd244: r=8'd24; 8'd245: r=8'd72; 8'd246: r=8'd243; 8'd247: r=8'd141;
			8'd248: r=8'd128; 8'd249: r=8'd195; 8'd250: r=8'd78; 8'd251: r=8'd66;
			8'd252: r=8'd215; 8'd253: r=8'd61; 8'd254: r=8'd156; 8'd255: r=8'd180;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	// hash mod 12 through a small compare chain (value < 256)
	function automatic logic [3:0] mod12(input logic [7:0] v);
		logic [7:0] a;
		a = v;
		if (a >= 8'd192) a = a - 8'd192;
		if (a >= 8'd96)  a = a - 8'd96;
		if (a >= 8'd48)  a = a - 8'd48;
		if (a >= 8'd24)  a = a - 8'd24;
		if (a >= 8'd12)  a = a - 8'd12;
		return a[3:0];
	endfunction

	// gradient dot product with offset
	function automatic logic signed [29:0] grad_dot(input logic [3:0] g,
			input logic signed [27:0] dx, input logic signed [27:0] dy);
		logic signed [29:0] x, y, r;
		x = 30'(dx);
		y = 30'(dy);
		case (g)
			4'd0: r = x + y;
			4'd1: r = y - x;
			4'd2: r = x - y;
			4'd3: r = -x - y;
			4'd4, 4'd6: r = x;
			4'd5, 4'd7: r = -x;
			4'd8, 4'd10: r = y;
			4'd9, 4'd11: r = -y;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== sv/sn2d_skew.sv =====
// Skew, cell index, corner offsets and gradient hash: four stages.
`default_nettype none
module sn2d_skew #(
	parameter int FRAC_BITS = sn2d_pkg::FracBitsDefault
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_vld,
	input  wire logic signed [31:0] x_in,
	input  wire logic signed [31:0] y_in,
	output logic                    out_vld,
	output sn2d_pkg::corner_t       c0,
	output sn2d_pkg::corner_t       c1,
	output sn2d_pkg::corner_t       c2
);
	localparam int Up = sn2d_pkg::Cfrac - FRAC_BITS;
	localparam int IW = 34 - FRAC_BITS; // cell index width

	// stage 1: (x+y)*F2
	logic signed [31:0] x_s1, y_s1;
	logic signed [57:0] prod_s1;
	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [32:0] sum_xy;
	assign sum_xy = 33'(x_in) + 33'(y_in);

	// stage 2: cell indices
	logic signed [31:0] x_s2, y_s2;
	logic signed [IW-1:0] i_s2, j_s2;
	logic signed [33:0] s_w, xs_w, ys_w;
	assign s_w  = 34'(prod_s1 >>> sn2d_pkg::Cfrac);
	assign xs_w = 34'(x_s1) + s_w;
	assign ys_w = 34'(y_s1) + s_w;

	// stage 3: offsets in Q.24 and permutation of j
	logic signed [27:0] x0_s3, y0_s3;
	logic [7:0] ii_s3, jj_s3, pj0_s3, pj2_s3;
	logic signed [IW:0] ij_w;
	logic signed [IW+24:0] tg_w;
	logic signed [27:0] fx_w, fy_w, x0_w, y0_w;
	logic io_w;
	assign ij_w = (IW+1)'(i_s2) + (IW+1)'(j_s2);
	assign tg_w = (IW+25)'(ij_w) * $signed({1'b0, sn2d_pkg::G2Q24});
	// terms wrap at 28 bits; only their sum, a small offset, has to fit
	assign fx_w = 28'(x_s2 - (32'(i_s2) <<< FRAC_BITS)) <<< Up;
	assign fy_w = 28'(y_s2 - (32'(j_s2) <<< FRAC_BITS)) <<< Up;
	assign x0_w = fx_w + 28'(tg_w);
	assign y0_w = fy_w + 28'(tg_w);
	assign io_w = x0_w > y0_w;

	logic io_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_vld; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= x_in;
		y_s1 <= y_in;
		prod_s1 <= 58'(sum_xy) * $signed({1'b0, sn2d_pkg::F2Q24});
		x_s2 <= x_s1;
		y_s2 <= y_s1;
		i_s2 <= IW'(xs_w >>> FRAC_BITS);
		j_s2 <= IW'(ys_w >>> FRAC_BITS);
		x0_s3 <= x0_w;
		y0_s3 <= y0_w;
		io_s3 <= io_w;
		ii_s3 <= i_s2[7:0];
		jj_s3 <= j_s2[7:0];
		pj0_s3 <= sn2d_pkg::perm_at(j_s2[7:0]);
		pj2_s3 <= sn2d_pkg::perm_at(j_s2[7:0] + 8'd1);
	end

	// stage 4: outer permutation, mod 12, corner offsets
	always_ff @(posedge clk) begin
		c0.dx <= x0_s3;
		c0.dy <= y0_s3;
		c0.grad <= sn2d_pkg::mod12(sn2d_pkg::perm_at(ii_s3 + pj0_s3));
		c1.dx <= x0_s3 - (io_s3 ? sn2d_pkg::OneQ24 : 28'sd0) + 28'(sn2d_pkg::G2Q24);
		c1.dy <= y0_s3 - (io_s3 ? 28'sd0 : sn2d_pkg::OneQ24) + 28'(sn2d_pkg::G2Q24);
		// middle corner steps in x or y: pick the matching inner hash
		c1.grad <= sn2d_pkg::mod12(sn2d_pkg::perm_at(ii_s3 + 8'(io_s3)
			+ (io_s3 ? pj0_s3 : pj2_s3)));
		c2.dx <= x0_s3 - sn2d_pkg::OneQ24 + 28'(2 * sn2d_pkg::G2Q24);
		c2.dy <= y0_s3 - sn2d_pkg::OneQ24 + 28'(2 * sn2d_pkg::G2Q24);
		c2.grad <= sn2d_pkg::mod12(sn2d_pkg::perm_at(ii_s3 + 8'd1 + pj2_s3));
	end

	assign out_vld = v_s4;
endmodule
`default_nettype wire

// ===== sv/sn2d_corner.sv =====
// One corner's contribution t^4 * dot in Q.48: five stages.
`default_nettype none
module sn2d_corner (
	input  wire logic               clk,
	input  wire sn2d_pkg::corner_t  cin,
	output logic signed [55:0]      contrib
);
	// stage 1: squares and dot
	logic [55:0] sqx_s1, sqy_s1;
	logic signed [29:0] dot_s1, dot_s2, dot_s3, dot_s4;
	// stage 2: t
	logic signed [28:0] t_s2;
	logic signed [57:0] t_w;
	// stage 3: t^2, stage 4: t^4, stage 5: t^4 * dot
	logic [23:0] t2_s3;
	logic neg_s3, neg_s4;
	logic [47:0] t2sq_w;
	logic [23:0] t4_w;
	logic [23:0] t4_s4;

	assign t_w = 58'(sn2d_pkg::HalfQ24) - 58'(sqx_s1 >> sn2d_pkg::Cfrac)
		- 58'(sqy_s1 >> sn2d_pkg::Cfrac);
	assign t2sq_w = 48'(t2_s3) * 48'(t2_s3);
	assign t4_w = t2sq_w[47:24];

	always_ff @(posedge clk) begin
		sqx_s1 <= 56'(cin.dx) * 56'(cin.dx);
		sqy_s1 <= 56'(cin.dy) * 56'(cin.dy);
		dot_s1 <= sn2d_pkg::grad_dot(cin.grad, cin.dx, cin.dy);
		t_s2   <= (t_w < 0) ? -29'sd1 : 29'(t_w);
		dot_s2 <= dot_s1;
		// t is at most 2^23, so t^2 fits 24 bits after the shift
		t2_s3  <= 24'((48'(t_s2[23:0]) * 48'(t_s2[23:0])) >> sn2d_pkg::Cfrac);
		neg_s3 <= t_s2 < 0;
		dot_s3 <= dot_s2;
		t4_s4  <= t4_w;
		neg_s4 <= neg_s3;
		dot_s4 <= dot_s3;
		contrib <= neg_s4 ? 56'sd0 : 56'($signed({1'b0, t4_s4})) * 56'(dot_s4);
	end
endmodule
`default_nettype wire

// ===== sv/sn2d_sum.sv =====
// Corner sum, scale by 70, round and saturate: two stages.
`default_nettype none
module sn2d_sum (
	input  wire logic               clk,
	input  wire logic signed [55:0] a,
	input  wire logic signed [55:0] b,
	input  wire logic signed [55:0] c,
	output logic signed [15:0]      result
);
	logic signed [57:0] sum_s1;
	logic signed [64:0] sc_w, r_w;

	assign sc_w = 65'(sum_s1) * 65'sd70 + (65'sd1 <<< 32);
	assign r_w = sc_w >>> 33;

	always_ff @(posedge clk) begin
		sum_s1 <= 58'(a) + 58'(b) + 58'(c);
		if (r_w > 65'sd32767)
			result <= 16'sd32767;
		else if (r_w < -65'sd32768)
			result <= -16'sd32768;
		else
			result <= 16'(r_w);
	end
endmodule
`default_nettype wire

// ===== sv/simplex_noise_2d_unit.sv =====
// Top level of the 2D simplex noise unit.
//  channel | signals                 | handshake
//  in      | x_coord, y_coord        | start high, busy low
//  out     | noise_value             | done strobe, one cycle
// One point per clock.
// The result passes the skew/hash pipeline (4), the corner multipliers (5)
// and the scale/saturate stage (2) before done strobes. busy is always low.
// Reset clears only the valid bits of the pipeline.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module simplex_noise_2d_unit #(
	parameter int FRAC_BITS = sn2d_pkg::FracBitsDefault
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] x_coord,
	input  wire logic signed [31:0] y_coord,
	output logic                    done,
	output logic signed [15:0]      noise_value
);
	sn2d_pkg::corner_t c0, c1, c2;
	logic hv;
	logic signed [55:0] k0, k1, k2;
	logic [6:0] vld_q;

	assign busy = 1'b0;

	sn2d_skew #(.FRAC_BITS(FRAC_BITS)) u_skew (
		.clk, .arst_n, .in_vld(start & ~busy), .x_in(x_coord), .y_in(y_coord),
		.out_vld(hv), .c0, .c1, .c2
	);
	sn2d_corner u_c0 (.clk, .cin(c0), .contrib(k0));
	sn2d_corner u_c1 (.clk, .cin(c1), .contrib(k1));
	sn2d_corner u_c2 (.clk, .cin(c2), .contrib(k2));
	sn2d_sum u_sum (.clk, .a(k0), .b(k1), .c(k2), .result(noise_value));

	// corner (5) and sum (2) stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[5:0], hv};
		end
	end
	assign done = vld_q[6];

	a_busy_low: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_done_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 11)) else $error("done without start");
	a_hash_follow: assert property (@(posedge clk) disable iff (!arst_n)
		hv |=> vld_q[0]) else $error("valid lost");
endmodule
`default_nettype wire
